// ----- rtl/core/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the sliding window maximum unit.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int SAMPLE_W       = 31;
  localparam int WLEN_W         = 9;
  localparam int DEF_MAX_WINDOW = 256;
  localparam int DATA_W         = 32;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int REG_IDX_W      = 1;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
  localparam logic [WLEN_W-1:0]    WLEN_RESET        = 9'd1;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic shift;
    logic restart;
  } swm_cell_ctrl_t;

endpackage

// ----- rtl/core/sliding_window_maximum_unit.sv -----
// ----------------------------------------------------------------------------
// sliding_window_maximum_unit
// Maximum of the last window_length samples of a stream, one result a sample once the window is full.
// ----------------------------------------------------------------------------
// The unit takes one sample per clock while its output is not stalled. Cell k of a row of MAX_WINDOW cells
// holds the maximum of the newest k+1 samples; every accepted sample shifts
// the row by one cell while each cell folds in the new sample, so a result
// is one compare and one cell select away and leaves through an output
// register in the cycle after its sample is accepted. A sample with tuser set
// starts a new stream; results appear once window_length samples of the
// current stream have arrived. window_length is written at byte address 0;
// 0 acts as 1 and values above MAX_WINDOW act as MAX_WINDOW.
module sliding_window_maximum_unit
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,    // sample_value, zero pad
  input  logic                  in_tuser,    // stream_start
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_W-1:0]     out_tdata,   // window_max, zero pad
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int EW    = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;

  logic [WLEN_W-1:0] wlen_r;
  logic [CNT_W-1:0]  seen_r, seen_nxt;
  logic              out_valid_r;
  sample_t           out_max_r, out_max_nxt;

  logic              in_xfer, out_xfer, cfg_wr;
  logic [EW-1:0]     wlen_ext, eff_w, eff_m2, seen_ext;
  logic [IDX_W-1:0]  tap_idx;
  sample_t           sample, tap_max;
  swm_cell_ctrl_t    cell_ctrl;
  sample_t           cell_max [MAX_WINDOW];

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[CFG_ADDR_W-1:2] == REG_WINDOW_LENGTH);
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_WINDOW_LENGTH)
                      ? CFG_DATA_W'(wlen_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WLEN_RESET;
    end else if (cfg_wr) begin
      wlen_r <= cfg_pwdata[WLEN_W-1:0];
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_valid_r && out_tready;
  assign sample    = in_tdata[SAMPLE_W-1:0];

  assign cell_ctrl.shift   = in_xfer;
  assign cell_ctrl.restart = in_tuser;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        swm_cell u_cell (
          .clk      (clk),
          .ctrl     (cell_ctrl),
          .sample   (sample),
          .prev_max (sample),
          .max_r    (cell_max[gi])
        );
      end else begin : g_body
        swm_cell u_cell (
          .clk      (clk),
          .ctrl     (cell_ctrl),
          .sample   (sample),
          .prev_max (cell_max[gi-1]),
          .max_r    (cell_max[gi])
        );
      end
    end
  endgenerate

  // effective window after clamping
  assign wlen_ext = EW'(wlen_r);
  always_comb begin
    if (wlen_r == '0) begin
      eff_w = EW'(1);
    end else if (wlen_ext > EW'(MAX_WINDOW)) begin
      eff_w = EW'(MAX_WINDOW);
    end else begin
      eff_w = wlen_ext;
    end
  end

  assign eff_m2  = eff_w - EW'(2);
  assign tap_idx = eff_m2[IDX_W-1:0];
  assign tap_max = cell_max[tap_idx];

  always_comb begin
    if (in_tuser) begin
      seen_nxt = CNT_W'(1);
    end else if (seen_r == CNT_W'(MAX_WINDOW)) begin
      seen_nxt = seen_r;
    end else begin
      seen_nxt = seen_r + CNT_W'(1);
    end
  end
  assign seen_ext = EW'(seen_nxt);

  always_comb begin
    if ((eff_w == EW'(1)) || (sample >= tap_max)) begin
      out_max_nxt = sample;
    end else begin
      out_max_nxt = tap_max;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        seen_r      <= seen_nxt;
        out_valid_r <= (seen_ext >= eff_w);
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_max_r <= out_max_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_max_r);

endmodule

// ----- rtl/core/swm_cell.sv -----
// ----------------------------------------------------------------------------
// swm_cell
// One cell of the running maximum chain: holds the maximum over the newest
// samples up to its own age and hands it to the next cell on each shift.
// ----------------------------------------------------------------------------
module swm_cell
  import swm_pkg::*;
(
  input  logic           clk,
  input  swm_cell_ctrl_t ctrl,
  input  sample_t        sample,
  input  sample_t        prev_max,
  output sample_t        max_r
);

  sample_t max_nxt;

  always_comb begin
    if (ctrl.restart || (sample >= prev_max)) begin
      max_nxt = sample;
    end else begin
      max_nxt = prev_max;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      max_r <= max_nxt;
    end
  end

endmodule

// ----- rtl/core/swm_checker.sv -----
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks of the sliding window maximum unit, bound to the top.
// ----------------------------------------------------------------------------
module swm_checker
  import swm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata
);

  // held result must not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[DATA_W-1] == 1'b0))
    else $error("pad bit set in result");

  // a stalled result blocks input, a free output slot takes it
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready inconsistent with output slot");

  // no result appears without an input transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid ##1 out_tvalid |-> $past(in_tvalid && in_tready))
    else $error("result without input transfer");

endmodule

bind sliding_window_maximum_unit swm_checker u_swm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
